[design/lprd_pkg.sv]
// Shared types and codes for the length-prefixed record deframer.
// No dependencies; compile first.
package lprd_pkg;

  // Position inside the current record
  typedef enum logic [2:0] {
    PH_NAME_LEN = 3'd0,
    PH_NAME     = 3'd1,
    PH_TIME     = 3'd2,
    PH_DATA_LEN = 3'd3,
    PH_DATA     = 3'd4
  } phase_t;

  // Role of each result beat
  typedef enum logic [2:0] {
    K_ABSORB = 3'd0,
    K_NAME   = 3'd1,
    K_DATA   = 3'd2,
    K_TIME   = 3'd3,
    K_STATUS = 3'd4
  } kind_t;

  // Payload close status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_MISMATCH  = 2'd2
  } status_t;

  // Item operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam int unsigned COUNT_W = 32;
  localparam int unsigned TS_W    = 64;

  // One input beat as held in the input register
  typedef struct packed {
    logic               op;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] announced_count;
  } item_t;

  // Handshake between the input register and the core
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

[design/lprd_if.sv]
// Stream interfaces for the deframer: input item channel and result channel.
// No dependencies.
interface lprd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  data_byte;
  logic [31:0] announced_count;

  modport source (output valid, op, data_byte, announced_count, input ready);
  modport sink   (input valid, op, data_byte, announced_count, output ready);
endinterface

interface lprd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [63:0] timestamp_ns;
  logic        record_end;
  logic [1:0]  status;
  logic [31:0] record_count;

  modport source (output valid, kind, out_byte, timestamp_ns, record_end, status,
                  record_count, input ready);
  modport sink   (input valid, kind, out_byte, timestamp_ns, record_end, status,
                  record_count, output ready);
endinterface

[design/lprd_in_reg.sv]
// Input register of the deframer: one item beat per cycle if drained.
// Depends on lprd_pkg and lprd_in_if.
module lprd_in_reg (
  input  logic           clk,
  input  logic           rst,
  lprd_in_if.sink        item,
  input  logic           take,
  output lprd_pkg::stage_t stage
);
  import lprd_pkg::*;

  logic  valid;
  item_t held;

  // Accept whenever the register is empty or being drained this cycle
  assign item.ready = !valid || take;

  // Hold the beat until the core takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item.ready) begin
      valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      held.op              <= item.op;
      held.data_byte       <= item.data_byte;
      held.announced_count <= item.announced_count;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = held;

endmodule

[design/lprd_core.sv]
// Deframer core: record state, per-byte decode and the result register.
// Depends on lprd_pkg and lprd_out_if.
module lprd_core (
  input  logic             clk,
  input  logic             rst,
  input  lprd_pkg::stage_t stage,
  output logic             take,
  lprd_out_if.source       result
);
  import lprd_pkg::*;

  // Record state
  phase_t             phase, phase_next;
  logic [31:0]        field_idx, field_idx_next;
  logic [15:0]        label_len, label_len_next;
  logic [TS_W-1:0]    ts_acc, ts_acc_next;
  logic [31:0]        body_len, body_len_next;
  logic [COUNT_W-1:0] completed, completed_next;

  // Result register
  logic               out_valid;
  kind_t              kind, kind_next;
  logic [7:0]         obyte, obyte_next;
  logic [TS_W-1:0]    ts_out, ts_out_next;
  logic               rend, rend_next;
  status_t            status, status_next;
  logic [COUNT_W-1:0] cnt, cnt_next;

  logic [31:0]        idx_inc;
  logic [COUNT_W-1:0] completed_inc;
  logic [7:0]         b;
  logic               advance;

  assign b             = stage.item.data_byte;
  assign idx_inc       = field_idx + 32'd1;
  assign completed_inc = (completed == '1) ? completed : completed + COUNT_W'(1);

  // Result register frees up when empty or taken this cycle
  assign advance = !out_valid || result.ready;
  assign take    = advance;

  // Decode one item against the current record state
  always_comb begin
    phase_next     = phase;
    field_idx_next = field_idx;
    label_len_next = label_len;
    ts_acc_next    = ts_acc;
    body_len_next  = body_len;
    completed_next = completed;
    kind_next      = K_ABSORB;
    obyte_next     = 8'd0;
    ts_out_next    = '0;
    rend_next      = 1'b0;
    status_next    = ST_OK;
    cnt_next       = completed;

    if (stage.item.op == OP_END) begin
      kind_next = K_STATUS;
      if (!(phase == PH_NAME_LEN && field_idx == 32'd0)) begin
        status_next = ST_TRUNCATED;
      end else if (completed != stage.item.announced_count) begin
        status_next = ST_MISMATCH;
      end
      cnt_next       = completed;
      phase_next     = PH_NAME_LEN;
      field_idx_next = 32'd0;
      label_len_next = 16'd0;
      ts_acc_next    = '0;
      body_len_next  = 32'd0;
      completed_next = '0;
    end else begin
      case (phase)
        PH_NAME: begin
          kind_next  = K_NAME;
          obyte_next = b;
          if (idx_inc >= {16'd0, label_len}) begin
            phase_next     = PH_TIME;
            field_idx_next = 32'd0;
            ts_acc_next    = '0;
          end else begin
            field_idx_next = idx_inc;
          end
        end
        PH_TIME: begin
          ts_acc_next = ts_acc | (TS_W'(b) << {field_idx[2:0], 3'b000});
          if (field_idx[2:0] == 3'd7) begin
            kind_next      = K_TIME;
            ts_out_next    = ts_acc_next;
            phase_next     = PH_DATA_LEN;
            field_idx_next = 32'd0;
            body_len_next  = 32'd0;
          end else begin
            field_idx_next = idx_inc;
          end
        end
        PH_DATA_LEN: begin
          body_len_next = body_len | (32'(b) << {field_idx[1:0], 3'b000});
          if (field_idx[1:0] == 2'd3) begin
            field_idx_next = 32'd0;
            if (body_len_next == 32'd0) begin
              // Empty data: the length field closes the record
              rend_next      = 1'b1;
              completed_next = completed_inc;
              phase_next     = PH_NAME_LEN;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            field_idx_next = idx_inc;
          end
        end
        PH_DATA: begin
          kind_next  = K_DATA;
          obyte_next = b;
          if (idx_inc == body_len) begin
            rend_next      = 1'b1;
            completed_next = completed_inc;
            phase_next     = PH_NAME_LEN;
            field_idx_next = 32'd0;
          end else begin
            field_idx_next = idx_inc;
          end
        end
        default: begin
          // Name length, low byte then high byte
          if (field_idx == 32'd0) begin
            label_len_next = {8'd0, b};
            field_idx_next = 32'd1;
          end else begin
            label_len_next = label_len | {b, 8'd0};
            field_idx_next = 32'd0;
            ts_acc_next    = '0;
            phase_next     = (label_len_next == 16'd0) ? PH_TIME : PH_NAME;
          end
        end
      endcase
      cnt_next = completed_next;
    end
  end

  // Advance state and load the result when the held item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NAME_LEN;
      field_idx <= 32'd0;
      label_len <= 16'd0;
      ts_acc    <= '0;
      body_len  <= 32'd0;
      completed <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage.valid;
      if (stage.valid) begin
        phase     <= phase_next;
        field_idx <= field_idx_next;
        label_len <= label_len_next;
        ts_acc    <= ts_acc_next;
        body_len  <= body_len_next;
        completed <= completed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.valid) begin
      kind   <= kind_next;
      obyte  <= obyte_next;
      ts_out <= ts_out_next;
      rend   <= rend_next;
      status <= status_next;
      cnt    <= cnt_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = kind;
  assign result.out_byte     = obyte;
  assign result.timestamp_ns = ts_out;
  assign result.record_end   = rend;
  assign result.status       = status;
  assign result.record_count = cnt;

`ifndef ASSERT_OFF
  a_rend_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && rend |-> kind == K_DATA || kind == K_ABSORB)
    else $error("record end on a beat that cannot close a record");

  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> kind == K_STATUS)
    else $error("non-ok status outside a status beat");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && stage.valid && stage.item.op == OP_END |=>
      phase == PH_NAME_LEN && field_idx == 32'd0 && completed == '0)
    else $error("end of payload did not clear record state");

  a_len_idx: assert property (@(posedge clk) disable iff (rst)
    phase == PH_NAME_LEN |-> field_idx <= 32'd1)
    else $error("name length index out of range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance && stage.valid && stage.item.op == OP_BYTE && rend_next |=>
      completed == $past(completed_inc))
    else $error("record count not advanced on record end");
`endif

endmodule

[design/length_prefixed_record_deframer.sv]
// Top level of the length-prefixed record deframer.
// Depends on lprd_pkg, lprd_if, lprd_in_reg and lprd_core.
//
// Usage:
//   item   : input channel, one payload byte (op 0) or an end-of-payload beat
//            (op 1, with announced_count) per accepted beat.
//   result : exactly one result beat per item: a tagged name or data byte,
//            an absorbed length/timestamp byte, the finished timestamp, or the
//            payload status with the record count.
// Path: an accepted item is held in the input register, then decoded into
//   the result register, where its result is valid until it is taken.
// Throughput: one item per cycle while result.ready is high; decode of a byte
//   is a single pass of logic between the two registers.
// Stalls: while result.ready is low the result register holds, the input
//   register fills, and item.ready drops only once both are occupied; no
//   beat is lost or repeated.
// Reset: synchronous, active high; both registers empty, record state back
//   to expecting a name length with the record count at zero.
module length_prefixed_record_deframer (
  input  logic       clk,
  input  logic       rst,
  lprd_in_if.sink    item,
  lprd_out_if.source result
);
  import lprd_pkg::*;

  stage_t stage;
  logic   take;

  lprd_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .take  (take),
    .stage (stage)
  );

  lprd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .stage  (stage),
    .take   (take),
    .result (result)
  );

endmodule
